// ----- rtl/core/modexp_pkg.sv -----
// shared constants and types for the modular exponentiation block
package modexp_pkg;

	localparam int MODULUS_DEF  = 100000007;
	localparam int EXP_BITS_DEF = 31;

	localparam int BASE_W   = 32;
	localparam int EXPO_W   = 31;
	localparam int RESULT_W = 27;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

// ----- rtl/core/modular_exponentiation.sv -----
// modular exponentiation top level: sequencer around a shared modular multiplier
//
// input channel: base_value and exponent_value, taken when in_valid is high and
// in_stall is low. in_stall stays high from the accepting edge until the result
// has been moved into the output register, so one transaction is in flight.
// output channel: power_result with out_valid, taken when out_stall is low.
// the result waits in the output register while out_stall is high, and the
// sequencer holds its last step until that register is free.
// each modular multiply or square runs in the bit-serial unit with a start step and
// a finish step. from the accepting edge to out_valid the sequencer runs the base
// reduction, then a multiply per set exponent bit and a squaring per bit below the
// top set bit, then completion; a zero exponent goes straight to completion.
// only one transaction is taken at a time, as all steps share the single
// multiplier.
// reset clears the sequencer and out_valid.
module modular_exponentiation import modexp_pkg::*; #(
	parameter int MODULUS  = MODULUS_DEF,
	parameter int EXP_BITS = EXP_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [BASE_W-1:0]   base_value,
	input  logic [EXPO_W-1:0]   exponent_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [RESULT_W-1:0] power_result
);

	localparam int RES_W = $clog2(MODULUS);
	localparam logic [RES_W:0] MOD_R = (RES_W+1)'(64'(MODULUS));

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_DEC  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_SQR  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]          state_q;
	logic [EXP_BITS-1:0] expo_q;
	logic [RES_W-1:0]    acc_q;
	logic [RES_W-1:0]    pow_q;
	logic                out_valid_q;
	logic [RESULT_W-1:0] power_q;

	logic                accept;
	logic                out_free;
	logic                mm_start;
	logic [RES_W-1:0]    mm_a;
	logic [BASE_W-1:0]   mm_b;
	logic [RES_W-1:0]    mm_r;
	mm_stat_t            mm_stat;

	logic [EXPO_W+EXP_BITS-1:0] expo_ext;
	logic [RES_W+RESULT_W-1:0]  acc_ext;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign expo_ext = {{EXP_BITS{1'b0}}, exponent_value};
	assign acc_ext  = {{RESULT_W{1'b0}}, acc_q};

	// operand select for the shared unit
	always_comb begin
		mm_start = 1'b0;
		mm_a     = pow_q;
		mm_b     = BASE_W'(pow_q);
		unique case (state_q)
			ST_IDLE: begin
				mm_start = accept;
				mm_a     = RES_W'(1);
				mm_b     = base_value;
			end
			ST_DEC: begin
				mm_start = (expo_q != '0);
				mm_a     = expo_q[0] ? acc_q : pow_q;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	modexp_mulmod #(
		.MODULUS(MODULUS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a_in   (mm_a),
		.b_in   (mm_b),
		.r_out  (mm_r),
		.stat   (mm_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_RED;
				end
				ST_RED, ST_MUL, ST_SQR: begin
					if (mm_stat.done) state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (expo_q == '0) begin
						state_q <= ST_DONE;
					end else if (expo_q[0]) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			expo_q <= expo_ext[EXP_BITS-1:0];
			acc_q  <= RES_W'(1);
		end
		if (mm_stat.done) begin
			case (state_q)
				ST_RED: pow_q <= mm_r;
				ST_MUL: begin
					acc_q     <= mm_r;
					expo_q[0] <= 1'b0;
				end
				ST_SQR: begin
					pow_q  <= mm_r;
					expo_q <= expo_q >> 1;
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_DONE && out_free) begin
			power_q <= acc_ext[RESULT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign power_result = power_q;

	a_done_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		mm_stat.done |-> (state_q == ST_RED || state_q == ST_MUL || state_q == ST_SQR))
		else $error("multiplier finished outside an operation");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> mm_stat.busy && state_q == ST_RED)
		else $error("accepted transaction did not start reduction");

	a_residues: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DEC |-> ({1'b0, acc_q} < MOD_R) && ({1'b0, pow_q} < MOD_R))
		else $error("running value not reduced");

	a_done_hands_off: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> state_q == ST_IDLE && out_valid_q)
		else $error("result not handed to output register");

endmodule

// ----- rtl/core/modexp_mulmod.sv -----
// shared bit-serial modular multiplier, one multiplier bit per cycle
module modexp_mulmod import modexp_pkg::*; #(
	parameter int MODULUS = MODULUS_DEF,
	localparam int RES_W = $clog2(MODULUS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RES_W-1:0]  a_in,
	input  logic [BASE_W-1:0] b_in,
	output logic [RES_W-1:0]  r_out,
	output mm_stat_t          stat
);

	localparam int CNT_W = $clog2(BASE_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BASE_W - 1);
	localparam logic [RES_W+1:0] MOD1_C = (RES_W+2)'(64'(MODULUS));
	localparam logic [RES_W+1:0] MOD2_C = (RES_W+2)'(64'(MODULUS) * 64'd2);

	logic [RES_W-1:0]  r_q;
	logic [RES_W-1:0]  a_q;
	logic [BASE_W-1:0] b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [RES_W+1:0]  add_v;
	logic [RES_W+1:0]  sum_v;
	logic [RES_W+1:0]  sub1_v;
	logic [RES_W+1:0]  sub2_v;
	logic [RES_W-1:0]  r_next;

	// r = 2r + bit*a stays below 3m, so at most two subtracts
	always_comb begin
		add_v  = b_q[BASE_W-1] ? {2'b00, a_q} : '0;
		sum_v  = {1'b0, r_q, 1'b0} + add_v;
		sub1_v = sum_v - MOD1_C;
		sub2_v = sum_v - MOD2_C;
		if (sum_v >= MOD2_C) begin
			r_next = sub2_v[RES_W-1:0];
		end else if (sum_v >= MOD1_C) begin
			r_next = sub1_v[RES_W-1:0];
		end else begin
			r_next = sum_v[RES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= a_in;
			b_q <= b_in;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[BASE_W-2:0], 1'b0};
		end
	end

	assign r_out     = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// partial remainder stays a residue while iterating
	a_r_residue: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |-> {2'b00, r_q} < MOD1_C)
		else $error("partial remainder out of range");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("done without a running operation");

endmodule

// ----- tb/modexp_checker.sv -----
// power result checker: predicts base^exponent mod modulus and compares each transaction
module modexp_checker import modexp_pkg::*; #(
	parameter int MODULUS  = MODULUS_DEF,
	parameter int EXP_BITS = EXP_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [BASE_W-1:0]   base_value,
	input  logic [EXPO_W-1:0]   exponent_value,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [RESULT_W-1:0] power_result,
	output int unsigned         errors,
	output int unsigned         outstanding
);

	localparam longint unsigned MOD = MODULUS;

	typedef struct {
		logic [BASE_W-1:0]   base;
		logic [EXPO_W-1:0]   expo;
		logic [RESULT_W-1:0] power;
	} power_job_t;

	power_job_t pending_powers[$];

	// right-to-left square and multiply
	function automatic logic [RESULT_W-1:0] predict_power(input logic [BASE_W-1:0] b,
			input logic [EXPO_W-1:0] e);
		longint unsigned sq;
		longint unsigned acc;
		longint unsigned ex;
		sq  = 64'(b);
		sq  = sq % MOD;
		acc = 1;
		acc = acc % MOD;
		ex  = 64'(e);
		for (int i = 0; i < EXP_BITS; i++) begin
			if (ex[i])
				acc = (acc * sq) % MOD;
			sq = (sq * sq) % MOD;
		end
		return acc[RESULT_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input power_job_t job,
			input logic [RESULT_W-1:0] got);
		$display("%0t: %s: base %0d exponent %0d expected %0d got %0d",
			$time, what, job.base, job.expo, job.power, got);
		errors++;
	endtask

	always @(posedge clk) begin
		power_job_t job;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_powers.size() == 0) begin
					job.base  = '0;
					job.expo  = '0;
					job.power = '0;
					report_mismatch("result with no transaction pending", job, power_result);
				end else begin
					job = pending_powers.pop_front();
					if (power_result !== job.power)
						report_mismatch("power_result mismatch", job, power_result);
				end
			end
			if (in_valid && !in_stall) begin
				job.base  = base_value;
				job.expo  = exponent_value;
				job.power = predict_power(base_value, exponent_value);
				pending_powers.push_back(job);
			end
			outstanding = pending_powers.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// testbench top: clock, reset, stimulus, idling, watchdog and verdict for modular_exponentiation
module tb import modexp_pkg::*;;

	localparam int MODULUS        = MODULUS_DEF;
	localparam int EXP_BITS       = EXP_BITS_DEF;
	localparam int RANDOM_ITEMS   = 1930;
	localparam int HOLD_CYCLES    = 3000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 100;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_stall;
	logic [BASE_W-1:0]   base_value     = '0;
	logic [EXPO_W-1:0]   exponent_value = '0;
	logic                out_valid;
	logic                out_stall      = 1'b0;
	logic [RESULT_W-1:0] power_result;

	int unsigned errors;
	int unsigned outstanding;
	int unsigned quiet_cycles  = 0;
	int unsigned send_idle_pct = 12;
	int unsigned recv_idle_pct = 66;
	logic        hold_go       = 1'b0;
	logic        holding       = 1'b0;

	always #1 clk = ~clk;

	modular_exponentiation #(
		.MODULUS  (MODULUS),
		.EXP_BITS (EXP_BITS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.power_result   (power_result)
	);

	modexp_checker #(
		.MODULUS  (MODULUS),
		.EXP_BITS (EXP_BITS)
	) power_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.power_result   (power_result),
		.errors         (errors),
		.outstanding    (outstanding)
	);

	always @(negedge clk)
		out_stall <= holding || ($urandom_range(99) < recv_idle_pct);

	// long receiver hold-off so the block fills and stalls its input
	initial begin
		wait (hold_go);
		@(negedge clk);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		holding <= 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [BASE_W-1:0] b, input logic [EXPO_W-1:0] e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		base_value     <= b;
		exponent_value <= e;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [BASE_W-1:0] pick_base();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return MODULUS * $urandom_range(42);
		else if (r < 16)
			return $urandom_range(3);
		else if (r < 22)
			return MODULUS * $urandom_range(41) + $urandom_range(1) * 2 - 1 + MODULUS;
		else
			return $urandom;
	endfunction

	// mostly short exponents keep the run short, a few reach full width
	function automatic logic [EXPO_W-1:0] pick_expo();
		int unsigned       r;
		int unsigned       len;
		logic [EXPO_W-1:0] mask;
		r = $urandom_range(99);
		if (r < 3)
			return EXPO_W'(MODULUS - 2);
		else if (r < 75)
			len = $urandom_range(6);
		else if (r < 92)
			len = $urandom_range(16, 7);
		else
			len = $urandom_range(EXPO_W, 17);
		mask = (31'h1 << len) - 31'h1;
		return EXPO_W'($urandom) & mask;
	endfunction

	initial begin
		int unsigned per_phase;
		per_phase = RANDOM_ITEMS / 3;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero exponent, zero base, multiples of the modulus, extremes, inverse
		send_item(32'd0, 31'd0);
		send_item(32'd0, 31'd5);
		send_item(MODULUS, 31'd0);
		send_item(MODULUS, 31'd7);
		send_item(2 * MODULUS, 31'd3);
		send_item(32'hFFFF_FFFF, 31'h7FFF_FFFF);
		send_item(32'hFFFF_FFFF, 31'd0);
		send_item(32'd0, 31'h7FFF_FFFF);
		send_item(32'd1, 31'h7FFF_FFFF);
		send_item(32'd2, 31'd10);
		send_item(MODULUS - 1, 31'd2);
		send_item(MODULUS - 1, 31'd3);
		send_item(32'd12345, EXPO_W'(MODULUS - 2));
		send_item(MODULUS + 1, 31'h7FFF_FFFF);
		send_item(32'd3, 31'h4000_0000);
		send_item(32'd5, 31'd1);
		send_item(32'h8000_0000, 31'h5555_5555);
		send_item(32'h7FFF_FFFF, 31'h2AAA_AAAA);
		send_item(MODULUS - 1, 31'h7FFF_FFFE);

		hold_go <= 1'b1;
		repeat (per_phase)
			send_item(pick_base(), pick_expo());

		send_idle_pct = 66;
		recv_idle_pct = 12;
		repeat (per_phase)
			send_item(pick_base(), pick_expo());

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (RANDOM_ITEMS - 2 * per_phase)
			send_item(pick_base(), pick_expo());
		in_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
